FILE: rtl/bsm_pkg.sv
// Shared types and helpers for the Booth radix-2 signed multiplier.
`default_nettype none

package bsm_pkg;

  // Action that one Booth recoding step applies to the accumulator.
  typedef enum logic [1:0] {
    BOOTH_HOLD,
    BOOTH_ADD,
    BOOTH_SUB
  } booth_op_t;

  // Decode the pair (multiplier bit 0, previous bit) into a Booth action.
  function automatic booth_op_t booth_op(input logic q0, input logic q_prev);
    booth_op_t op;
    unique case ({q0, q_prev})
      2'b01:   op = BOOTH_ADD;
      2'b10:   op = BOOTH_SUB;
      default: op = BOOTH_HOLD;
    endcase
    return op;
  endfunction

endpackage : bsm_pkg

`default_nettype wire

FILE: rtl/bsm_if.sv
// Valid/ready channel interfaces for operand and product transactions.
`default_nettype none

interface bsm_in_if #(
  parameter int WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] multiplicand;
  logic signed [WIDTH-1:0] multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface : bsm_in_if

interface bsm_out_if #(
  parameter int WIDTH = 16
);
  logic                      valid;
  logic                      ready;
  logic signed [2*WIDTH-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface : bsm_out_if

`default_nettype wire

FILE: rtl/booth_signed_multiplier.sv
// Top level of the pipelined Booth radix-2 signed multiplier.
//
//   channel | direction | payload                              | handshake
//   --------+-----------+--------------------------------------+-------------
//   in_if   | sink      | multiplicand[W-1:0], multiplier[W-1:0]| valid/ready
//   out_if  | source    | product[2W-1:0]                       | valid/ready
//
// An accepted transaction reaches out_if as a product through the pipeline stages:
// one pipeline stage per Booth iteration, each stage one (WIDTH+1)-bit add/sub.
// Throughput is one transaction per cycle while out_if is not stalled.
// rst_n (synchronous, active low) clears all stage valid bits; payload is not reset.
// A stall on out_if freezes the whole pipeline; in_if.ready drops in the same
// cycle, so nothing is lost or repeated. Bubbles are carried, not squeezed out.
`default_nettype none

module booth_signed_multiplier #(
  parameter int WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bsm_in_if.sink    in_if,
  bsm_out_if.source out_if
);

  // Per-stage state: accumulator A (one bit wider), multiplier/low half Q,
  // previous bit, multiplicand travelling alongside, and a valid bit.
  logic [WIDTH:0]   a_r  [WIDTH];
  logic [WIDTH-1:0] q_r  [WIDTH];
  logic             qp_r [WIDTH];
  logic [WIDTH-1:0] m_r  [WIDTH];
  logic [WIDTH-1:0] vld_r;

  logic [WIDTH:0]   a_nxt  [WIDTH];
  logic [WIDTH-1:0] q_nxt  [WIDTH];
  logic             qp_nxt [WIDTH];

  logic advance;

  // Advance whenever the last stage is empty or its product is being taken.
  assign advance     = !vld_r[WIDTH-1] || out_if.ready;
  assign in_if.ready = advance;

  // First iteration works straight off the input: A and q_prev start at zero.
  bsm_step #(.WIDTH(WIDTH)) u_step0 (
    .a_i  ('0),
    .q_i  (in_if.multiplier),
    .qp_i (1'b0),
    .m_i  (in_if.multiplicand),
    .a_o  (a_nxt[0]),
    .q_o  (q_nxt[0]),
    .qp_o (qp_nxt[0])
  );

  for (genvar k = 1; k < WIDTH; k++) begin : g_step
    bsm_step #(.WIDTH(WIDTH)) u_step (
      .a_i  (a_r[k-1]),
      .q_i  (q_r[k-1]),
      .qp_i (qp_r[k-1]),
      .m_i  (m_r[k-1]),
      .a_o  (a_nxt[k]),
      .q_o  (q_nxt[k]),
      .qp_o (qp_nxt[k])
    );
  end

  // Valid bits: clear on reset, shift forward on advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[WIDTH-2:0], in_if.valid};
    end
  end

  // Payload registers: hold while stalled, advance with the valid bits.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_r[0]  <= a_nxt[0];
      q_r[0]  <= q_nxt[0];
      qp_r[0] <= qp_nxt[0];
      m_r[0]  <= in_if.multiplicand;
      for (int k = 1; k < WIDTH; k++) begin
        a_r[k]  <= a_nxt[k];
        q_r[k]  <= q_nxt[k];
        qp_r[k] <= qp_nxt[k];
        m_r[k]  <= m_r[k-1];
      end
    end
  end

  // Product: upper half is A without its guard bit, lower half is Q.
  assign out_if.valid   = vld_r[WIDTH-1];
  assign out_if.product = {a_r[WIDTH-1][WIDTH-1:0], q_r[WIDTH-1]};

endmodule : booth_signed_multiplier

`default_nettype wire

FILE: rtl/bsm_step.sv
// One Booth radix-2 iteration: add/subtract into the upper half, then shift right.
`default_nettype none

module bsm_step #(
  parameter int WIDTH = 16
) (
  input  wire logic [WIDTH:0]   a_i,
  input  wire logic [WIDTH-1:0] q_i,
  input  wire logic             qp_i,
  input  wire logic [WIDTH-1:0] m_i,
  output logic      [WIDTH:0]   a_o,
  output logic      [WIDTH-1:0] q_o,
  output logic                  qp_o
);
  import bsm_pkg::*;

  logic [WIDTH:0] m_ext;
  logic [WIDTH:0] sum;
  booth_op_t      op;

  assign m_ext = {m_i[WIDTH-1], m_i};
  assign op    = booth_op(q_i[0], qp_i);

  always_comb begin
    unique case (op)
      BOOTH_ADD:  sum = a_i + m_ext;
      BOOTH_SUB:  sum = a_i - m_ext;
      BOOTH_HOLD: sum = a_i;
      default:    sum = a_i;
    endcase
  end

  // Arithmetic shift of {A, Q, q_prev} by one place.
  assign a_o  = {sum[WIDTH], sum[WIDTH:1]};
  assign q_o  = {sum[0], q_i[WIDTH-1:1]};
  assign qp_o = q_i[0];

endmodule : bsm_step

`default_nettype wire

FILE: rtl/bsm_chk.sv
// Port-level checker for the Booth multiplier, bound to the top level.
`default_nettype none

module bsm_chk #(
  parameter int WIDTH = 16
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2*WIDTH-1:0] out_product
);

  // A stalled product stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("product dropped while stalled");

  // A stalled product does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_product))
    else $error("product changed while stalled");

  // Input side follows the output stall in the same cycle.
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("product offered right after reset");

  // Keep in_valid observed for completeness of the port view.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$isunknown(in_ready))
    else $error("input ready unknown after transaction");

endmodule : bsm_chk

bind booth_signed_multiplier bsm_chk #(.WIDTH(WIDTH)) u_bsm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_product (out_if.product)
);

`default_nettype wire
